### rtl/scp_pkg.sv
package scp_pkg;

   // transfer kinds on the request opcode field
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_ID_VALUE   = 2'd0;
   localparam logic [1:0] CSR_CACHE_TYPE = 2'd1;
   localparam logic [1:0] CSR_BIG_ENDIAN = 2'd2;

   // primary register numbers
   localparam logic [3:0] PRIM_ID       = 4'd0;
   localparam logic [3:0] PRIM_CONTROL  = 4'd1;
   localparam logic [3:0] PRIM_TBASE    = 4'd2;
   localparam logic [3:0] PRIM_DOMAIN   = 4'd3;
   localparam logic [3:0] PRIM_FSR      = 4'd5;
   localparam logic [3:0] PRIM_FAR      = 4'd6;
   localparam logic [3:0] PRIM_CACHE_OP = 4'd7;
   localparam logic [3:0] PRIM_TLB_OP   = 4'd8;
   localparam logic [3:0] PRIM_CPACC    = 4'd15;

   localparam int unsigned CPACC_W = 14;

   localparam logic [31:0] CTRL_CACHE_WBUF = 32'h0000_000c;
   localparam logic [31:0] CTRL_FIXED      = 32'h0000_0070;
   localparam int unsigned CTRL_BIG_BIT    = 7;
   localparam int unsigned CTRL_VEC_BIT    = 13;
   localparam logic [31:0] TBASE_MASK      = 32'hffff_c000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  first_opcode;
      logic [3:0]  primary_reg;
      logic [3:0]  secondary_reg;
      logic [2:0]  second_opcode;
      logic        privileged;
      logic [31:0] write_data;
   } scp_item_type;

   typedef struct packed {
      logic [31:0]        control;
      logic [31:0]        aux_control;
      logic [31:0]        table_base;
      logic [31:0]        domain_access;
      logic [CPACC_W-1:0] copro_access;
   } scp_regs_type;

   typedef struct packed {
      logic [31:0] id_value;
      logic [31:0] cache_type_value;
      logic        big_endian;
   } scp_cfg_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        undefined;
      logic        high_vectors;
      logic        flush_translation;
   } scp_result_type;

endpackage

### rtl/system_control_coprocessor.sv
// System control coprocessor register transfer block.
// req_ channel: one transfer word per handshake (opcode, first/second opcode,
//   primary and secondary register, privilege, write data).
// rsp_ channel: one result word per transfer, in order: read data, undefined
//   flag, high-vector select and translation flush pulse.
// csr_ channel: writes of the identification value, cache type value and
//   endianness; always ready. The user must write it only while the block is
//   idle (the block does not check). Words pass input and result registers.
// Throughput: one word per cycle while rsp_ready is high; decode and register
//   update sit in one combinational pass between input and result registers.
// Register state changes when a transfer leaves the input register, so the
//   effects land in request order.
// Reset (synchronous): both stages empty, control = 0x70, the other
//   registers and the configuration cleared.
// A stalled receiver holds the result register; the input register still
//   takes one more word, then req_ready drops until rsp_ready returns.
module system_control_coprocessor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [2:0]  req_first_opcode,
   input  logic [3:0]  req_primary_reg,
   input  logic [3:0]  req_secondary_reg,
   input  logic [2:0]  req_second_opcode,
   input  logic        req_privileged,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_undefined,
   output logic        rsp_high_vectors,
   output logic        rsp_flush_translation,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import scp_pkg::*;

   // input stage
   logic         in_valid_ff, in_valid_in;
   scp_item_type in_item_ff;

   // result stage
   logic           out_valid_ff, out_valid_in;
   scp_result_type out_ff;

   // architectural state and configuration
   scp_regs_type regs_ff, regs_in;
   scp_cfg_type  cfg_ff, cfg_in;

   scp_result_type result;
   logic           out_free;
   logic           advance;
   logic           take;

   // result register free this cycle, so the held word may move on
   assign out_free = !out_valid_ff || rsp_ready;
   assign advance  = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   scp_decode u_decode (
      .item      (in_item_ff),
      .regs      (regs_ff),
      .cfg       (cfg_ff),
      .regs_next (regs_in),
      .result    (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_free ? in_valid_ff : out_valid_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ID_VALUE:   cfg_in.id_value         = csr_write_data;
            CSR_CACHE_TYPE: cfg_in.cache_type_value = csr_write_data;
            CSR_BIG_ENDIAN: cfg_in.big_endian       = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         regs_ff      <= '{control: CTRL_FIXED, default: '0};
         cfg_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) begin
            regs_ff <= regs_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff.opcode        <= req_opcode;
         in_item_ff.first_opcode  <= req_first_opcode;
         in_item_ff.primary_reg   <= req_primary_reg;
         in_item_ff.secondary_reg <= req_secondary_reg;
         in_item_ff.second_opcode <= req_second_opcode;
         in_item_ff.privileged    <= req_privileged;
         in_item_ff.write_data    <= req_write_data;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_read_data         = out_ff.read_data;
   assign rsp_undefined         = out_ff.undefined;
   assign rsp_high_vectors      = out_ff.high_vectors;
   assign rsp_flush_translation = out_ff.flush_translation;

`ifndef NO_ASSERTIONS
   // a rejected transfer never returns data
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined |-> rsp_read_data == 32'd0)
      else $error("undefined transfer returned data");

   // a write (flush pulse) never returns data
   a_flush_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flush_translation |-> rsp_read_data == 32'd0)
      else $error("write returned data");

   // control register keeps fixed bits set and cache/write-buffer clear
   a_ctrl_fixed: assert property (@(posedge clock) disable iff (reset)
      ((regs_ff.control & CTRL_FIXED) == CTRL_FIXED)
      && ((regs_ff.control & CTRL_CACHE_WBUF) == 32'd0))
      else $error("control register fixed bits corrupted");

   // a held word is not dropped while the result register is blocked
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("input word lost during stall");
`endif

endmodule

### rtl/scp_decode.sv
module scp_decode (
   input  scp_pkg::scp_item_type   item,
   input  scp_pkg::scp_regs_type   regs,
   input  scp_pkg::scp_cfg_type    cfg,
   output scp_pkg::scp_regs_type   regs_next,
   output scp_pkg::scp_result_type result
);
   import scp_pkg::*;

   // cache maintenance variants that are accepted
   function automatic logic cache_op_ok(input logic [3:0] rm, input logic [2:0] op2);
      logic ok;
      begin
         unique case (rm)
            4'd2:    ok = (op2 == 3'd5);
            4'd5:    ok = (op2 != 3'd3) && (op2 != 3'd5);
            4'd6:    ok = (op2 <= 3'd2);
            4'd7:    ok = (op2 == 3'd0);
            4'd10:   ok = (op2 == 3'd1) || (op2 == 3'd2) || (op2 == 3'd4);
            default: ok = 1'b0;
         endcase
         return ok;
      end
   endfunction

   function automatic logic tlb_op_ok(input logic [3:0] rm, input logic [2:0] op2);
      return ((rm == 4'd5) || (rm == 4'd6) || (rm == 4'd7)) && (op2 <= 3'd1);
   endfunction

   logic        access_ok;
   logic [31:0] ctrl_word;

   assign access_ok = item.privileged && (item.first_opcode == 3'd0);

   always_comb begin
      ctrl_word = (item.write_data & ~CTRL_CACHE_WBUF) | CTRL_FIXED;
      ctrl_word[CTRL_BIG_BIT] = cfg.big_endian;
   end

   always_comb begin
      regs_next                = regs;
      result.read_data         = '0;
      result.undefined         = 1'b1;
      result.flush_translation = 1'b0;
      if (access_ok) begin
         unique case (item.opcode)
            OP_WRITE: begin
               result.flush_translation = 1'b1;
               unique case (item.primary_reg)
                  PRIM_CONTROL: begin
                     if (item.second_opcode == 3'd0) begin
                        regs_next.control = ctrl_word;
                        result.undefined  = 1'b0;
                     end else if (item.second_opcode == 3'd1) begin
                        regs_next.aux_control = item.write_data;
                        result.undefined      = 1'b0;
                     end
                  end
                  PRIM_TBASE: begin
                     regs_next.table_base = item.write_data & TBASE_MASK;
                     result.undefined     = 1'b0;
                  end
                  PRIM_DOMAIN: begin
                     regs_next.domain_access = item.write_data;
                     result.undefined        = 1'b0;
                  end
                  PRIM_CACHE_OP: begin
                     result.undefined = !cache_op_ok(item.secondary_reg, item.second_opcode);
                  end
                  PRIM_TLB_OP: begin
                     result.undefined = !tlb_op_ok(item.secondary_reg, item.second_opcode);
                  end
                  PRIM_CPACC: begin
                     if (item.secondary_reg == 4'd1) begin
                        regs_next.copro_access = item.write_data[CPACC_W-1:0];
                        result.undefined       = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            OP_READ: begin
               unique case (item.primary_reg)
                  PRIM_ID: begin
                     if (item.second_opcode == 3'd0) begin
                        result.read_data = cfg.id_value;
                        result.undefined = 1'b0;
                     end else if (item.second_opcode == 3'd1) begin
                        result.read_data = cfg.cache_type_value;
                        result.undefined = 1'b0;
                     end
                  end
                  PRIM_CONTROL: begin
                     if (item.second_opcode == 3'd0) begin
                        result.read_data = regs.control;
                        result.undefined = 1'b0;
                     end else if (item.second_opcode == 3'd1) begin
                        result.read_data = regs.aux_control;
                        result.undefined = 1'b0;
                     end
                  end
                  PRIM_TBASE: begin
                     result.read_data = regs.table_base;
                     result.undefined = 1'b0;
                  end
                  PRIM_DOMAIN: begin
                     result.read_data = regs.domain_access;
                     result.undefined = 1'b0;
                  end
                  PRIM_FSR, PRIM_FAR: begin
                     result.undefined = 1'b0;
                  end
                  PRIM_CPACC: begin
                     result.read_data = {{(32-CPACC_W){1'b0}}, regs.copro_access};
                     result.undefined = 1'b0;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
      // vector select reflects the control register after this transfer
      result.high_vectors = regs_next.control[CTRL_VEC_BIT];
   end

endmodule
